[sv/spq_pkg.sv]
`default_nettype none
package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 4;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

[sv/spq_ctrl.sv]
`default_nettype none
module spq_ctrl
	import spq_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire        m_tready,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// result register can take a new word if empty or being drained now
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		cmd.load_in = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

[sv/spq_dpath.sv]
`default_nettype none
module spq_dpath
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  ctrl_cmd_t                 cmd,
	input  wire                       func,
	input  wire signed [VALUE_W-1:0]  value,
	output status_t                   status,
	output logic [COUNT_W-1:0]        entry_count,
	output logic signed [VALUE_W-1:0] head_value
);

	localparam int CW = $clog2(DEPTH + 1);

	logic                      func_q;
	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] ent_q [DEPTH];
	logic [CW-1:0]             cnt_q;

	logic [DEPTH-1:0]          vld, ge, eq, hit;
	logic signed [VALUE_W-1:0] ins_ent [DEPTH];
	logic signed [VALUE_W-1:0] del_ent [DEPTH];
	logic signed [VALUE_W-1:0] nxt_ent [DEPTH];
	logic [CW-1:0]             nxt_cnt;
	status_t                   nxt_st;
	logic                      full, empty, upd;

	// per-cell compares, all in parallel
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			vld[i] = CW'(i) < cnt_q;
			ge[i]  = !vld[i] || (val_q >= ent_q[i]);
			eq[i]  = vld[i] && (val_q == ent_q[i]);
		end
		hit[0] = eq[0];
		for (int i = 1; i < DEPTH; i++) hit[i] = hit[i-1] | eq[i];
	end

	// insert: cells at and behind the insert point move back by one
	always_comb begin
		ins_ent[0] = ge[0] ? val_q : ent_q[0];
		for (int i = 1; i < DEPTH; i++) begin
			if (ge[i-1]) ins_ent[i] = ent_q[i-1];
			else if (ge[i]) ins_ent[i] = val_q;
			else ins_ent[i] = ent_q[i];
		end
	end

	// delete: cells from the first match on pull from their neighbor
	always_comb begin
		for (int i = 0; i < DEPTH - 1; i++)
			del_ent[i] = hit[i] ? ent_q[i+1] : ent_q[i];
		del_ent[DEPTH-1] = ent_q[DEPTH-1];
	end

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;

	always_comb begin
		nxt_st  = ST_OK;
		nxt_cnt = cnt_q;
		upd     = 1'b0;
		for (int i = 0; i < DEPTH; i++) nxt_ent[i] = ent_q[i];
		if (func_q == FUNC_INSERT) begin
			if (full) begin
				nxt_st = ST_FULL;
			end else begin
				upd     = 1'b1;
				nxt_cnt = cnt_q + CW'(1);
				for (int i = 0; i < DEPTH; i++) nxt_ent[i] = ins_ent[i];
			end
		end else begin
			if (empty) begin
				nxt_st = ST_EMPTY;
			end else if (!hit[DEPTH-1]) begin
				nxt_st = ST_NOTFOUND;
			end else begin
				upd     = 1'b1;
				nxt_cnt = cnt_q - CW'(1);
				for (int i = 0; i < DEPTH; i++) nxt_ent[i] = del_ent[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= func;
			val_q  <= value;
		end
		if (cmd.exec && upd) begin
			for (int i = 0; i < DEPTH; i++) ent_q[i] <= nxt_ent[i];
		end
		if (cmd.exec) begin
			status      <= nxt_st;
			entry_count <= COUNT_W'(nxt_cnt);
			head_value  <= (nxt_cnt != '0) ? nxt_ent[0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.exec) cnt_q <= nxt_cnt;
	end

endmodule
`default_nettype wire

[sv/sorted_priority_queue_unit.sv]
// sorted priority queue, descending order, head is the largest value
// flow: the idle state captures the word in the input register, then the exec state waits for a free
// result register and runs the compare-and-shift; no new word is accepted until that op is done
// the cell array compares every entry in parallel, the shift is done in the same cycle as the compares
// reset (arst_n low, asynchronous): queue empty, no result pending, ready to accept
`default_nettype none
module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// input word
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire [S_TDATA_W-1:0]   s_tdata,   // [31:0] value
	input  wire                   s_tuser,   // [0] func
	// result word
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // [3:0] entry_count, [35:4] head_value, [39:36] zero
	output logic [M_TUSER_W-1:0]  m_tuser    // [1:0] status
);

	// command bundle from the sequencer to the cell array
	ctrl_cmd_t                 cmd;
	status_t                   status;
	logic [COUNT_W-1:0]        entry_count;
	logic signed [VALUE_W-1:0] head_value;

	// sequencer: idle takes a word, exec runs the op once the result register is free
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// cell array plus result register
	spq_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (s_tuser),
		.value       (s_tdata[VALUE_W-1:0]),
		.status      (status),
		.entry_count (entry_count),
		.head_value  (head_value)
	);

	// pack result word, upper pad bits are zero
	assign m_tdata = {{(M_TDATA_W - COUNT_W - VALUE_W){1'b0}}, head_value, entry_count};
	assign m_tuser = status;

endmodule
`default_nettype wire

[sv/spq_checker.sv]
`default_nettype none
module spq_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  s_tvalid,
	input wire                  s_tready,
	input wire                  m_tvalid,
	input wire                  m_tready,
	input wire [M_TDATA_W-1:0]  m_tdata,
	input wire [M_TUSER_W-1:0]  m_tuser
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one op at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a word while busy");

	// full status only with a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[3:0] == 4'(DEPTH))
		else $error("full status with queue not full");

	// empty status reports zero count and zero head
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[35:0] == 36'd0)
		else $error("empty status with nonzero count or head");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
`default_nettype wire

[verif/sorted_priority_queue_checker.sv]
`default_nettype none
module sorted_priority_queue_checker
	import spq_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  s_tready,
	input  wire [S_TDATA_W-1:0]  s_tdata,   // [31:0] value
	input  wire                  s_tuser,   // [0] func
	input  wire                  m_tvalid,
	input  wire                  m_tready,
	input  wire [M_TDATA_W-1:0]  m_tdata,   // [3:0] entry_count, [35:4] head_value, [39:36] zero
	input  wire [M_TUSER_W-1:0]  m_tuser,   // [1:0] status
	output int                   mismatch_count,
	output int                   pending_count
);

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic [VALUE_W-1:0]   head;
	} queue_result_t;

	// shadow copy of the queue, descending order, slot 0 is the head
	logic [VALUE_W-1:0] held [DEPTH];
	int held_n;
	queue_result_t predicted_results [$];
	int fails;

	function automatic queue_result_t queue_step(input logic func, input logic [VALUE_W-1:0] value);
		queue_result_t r;
		int i;
		int j;
		r.status = ST_OK;
		if (func == FUNC_INSERT) begin
			if (held_n >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// newer equal values go in front of older ones
				i = 0;
				while (i < held_n && $signed(value) < $signed(held[i]))
					i++;
				for (j = held_n; j > i; j--)
					held[j] = held[j-1];
				held[i] = value;
				held_n++;
			end
		end else if (held_n == 0) begin
			r.status = ST_EMPTY;
		end else begin
			i = 0;
			while (i < held_n && held[i] != value)
				i++;
			if (i == held_n) begin
				r.status = ST_NOTFOUND;
			end else begin
				for (j = i; j + 1 < held_n; j++)
					held[j] = held[j+1];
				held_n--;
			end
		end
		r.count = COUNT_W'(held_n);
		r.head = (held_n > 0) ? held[0] : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		logic [COUNT_W-1:0] got_count;
		logic [VALUE_W-1:0] got_head;
		logic bad;
		int k;
		if (!arst_n) begin
			for (k = 0; k < DEPTH; k++)
				held[k] = '0;
			held_n = 0;
			predicted_results.delete();
			fails = 0;
			mismatch_count <= 0;
			pending_count <= 0;
		end else begin
			// results first, so a word that has no prediction yet is never matched
			if (m_tvalid && m_tready) begin
				got_count = m_tdata[COUNT_W-1:0];
				got_head = m_tdata[COUNT_W +: VALUE_W];
				if (predicted_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result word: status %0d count %0d head %0d",
							m_tuser, got_count, $signed(got_head));
				end else begin
					want = predicted_results.pop_front();
					bad = (m_tuser != want.status) || (got_count != want.count) ||
						(got_head != want.head) ||
						(m_tdata[M_TDATA_W-1:COUNT_W+VALUE_W] != '0);
					if (bad) begin
						fails++;
						if (fails <= 10)
							$display("result mismatch: expected status %0d count %0d head %0d, got status %0d count %0d head %0d pad %0h",
								want.status, want.count, $signed(want.head), m_tuser,
								got_count, $signed(got_head),
								m_tdata[M_TDATA_W-1:COUNT_W+VALUE_W]);
					end
				end
			end
			if (s_tvalid && s_tready)
				predicted_results.push_back(queue_step(s_tuser, s_tdata[VALUE_W-1:0]));
			mismatch_count <= fails;
			pending_count <= predicted_results.size();
		end
	end

endmodule
`default_nettype wire

[verif/sorted_priority_queue_unit_test.sv]
`default_nettype none
module sorted_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int DEPTH = 8;
	// words per random phase, three phases with different idle rates
	localparam int PHASE_WORDS = 600;
	// run guard limit, set well above the length of the slowest run
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;    // [31:0] value
	logic                 s_tuser = 1'b0;  // [0] func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // [3:0] entry_count, [35:4] head_value, [39:36] zero
	logic [M_TUSER_W-1:0] m_tuser;         // [1:0] status

	// idle rates in percent, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatch_count;
	int pending_count;
	int unsigned cycles = 0;

	// values inserted lately, so deletes mostly hit stored entries
	logic [VALUE_W-1:0] recent [$];

	sorted_priority_queue_unit #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	sorted_priority_queue_checker #(.DEPTH(DEPTH)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random stalls at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// idle at the current rate cycle by cycle, then offer one word and hold it until taken
	task automatic send_word(input logic func, input logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			// junk on the bus while idle, it must be ignored
			s_tdata <= $urandom;
			s_tuser <= 1'($urandom_range(1));
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= func;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// random words: insert share drifts so the queue swings between empty and full
	task automatic run_random(input int words);
		int ins_pct;
		int k;
		int idx;
		logic func;
		logic [VALUE_W-1:0] value;
		ins_pct = 50;
		for (k = 0; k < words; k++) begin
			if (k % 16 == 0)
				ins_pct = ($urandom_range(2) == 0) ? 80 : ($urandom_range(1) ? 25 : 55);
			func = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
			if (func == FUNC_DELETE && recent.size() > 0 && $urandom_range(99) < 70) begin
				idx = $urandom_range(recent.size() - 1);
				value = recent[idx];
				recent.delete(idx);
			end else begin
				// small values give plenty of ties, the rest spans the whole range
				case ($urandom_range(9))
					0, 1, 2, 3, 4: value = VALUE_W'($urandom_range(8)) - VALUE_W'(4);
					5: value = 32'h7fff_ffff;
					6: value = 32'h8000_0000;
					default: value = $urandom;
				endcase
				if (func == FUNC_INSERT) begin
					recent.push_back(value);
					if (recent.size() > 16)
						void'(recent.pop_front());
				end
			end
			send_word(func, value);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty delete, extremes, ties, fill to full, overflow, miss, drain
		send_word(FUNC_DELETE, 32'd0);
		send_word(FUNC_INSERT, 32'h7fff_ffff);
		send_word(FUNC_INSERT, 32'h8000_0000);
		send_word(FUNC_INSERT, 32'd0);
		send_word(FUNC_INSERT, 32'd0);
		send_word(FUNC_INSERT, 32'hffff_ffff);
		send_word(FUNC_INSERT, 32'd1);
		send_word(FUNC_INSERT, 32'h7fff_ffff);
		send_word(FUNC_INSERT, 32'h8000_0001);
		send_word(FUNC_INSERT, 32'd3);
		send_word(FUNC_INSERT, 32'h8000_0000);
		send_word(FUNC_DELETE, 32'd42);
		send_word(FUNC_DELETE, 32'h7fff_ffff);
		send_word(FUNC_DELETE, 32'h8000_0000);
		send_word(FUNC_DELETE, 32'd0);
		send_word(FUNC_DELETE, 32'h8000_0001);
		send_word(FUNC_DELETE, 32'h7fff_ffff);
		send_word(FUNC_DELETE, 32'hffff_ffff);
		send_word(FUNC_DELETE, 32'd1);
		send_word(FUNC_DELETE, 32'd1);
		send_word(FUNC_DELETE, 32'd0);
		send_word(FUNC_DELETE, 32'hffff_ffff);
		send_word(FUNC_INSERT, 32'h5555_aaaa);
		send_word(FUNC_DELETE, 32'h5555_aaaa);

		// sender idles more rarely than the receiver, then the reverse, then no idling
		send_idle_pct = 27;
		recv_idle_pct = 54;
		run_random(PHASE_WORDS);
		send_idle_pct = 54;
		recv_idle_pct = 27;
		run_random(PHASE_WORDS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_WORDS);
		s_tvalid <= 1'b0;

		// drain, then give stray words time to show up
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
